>>> rtl/mmds_pkg.sv
// Shared types, constants and codes for the mouse motion decay smoother.
`default_nettype none

package mmds_pkg;

  // Fixed-point layout of the accumulators and remainders.
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 24 + FRAC_BITS;
  localparam int FRAC_W    = FRAC_BITS + 2;

  // Stream and register port widths.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_MOUSE = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_MOUSE  = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_MOTION = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    KEY_DOWN  = 2'd0,
    KEY_UP    = 2'd1,
    KEY_OTHER = 2'd2
  } key_state_e;

  typedef enum logic [2:0] {
    REG_RETENTION       = 3'd0,
    REG_CTRL_KEY        = 3'd1,
    REG_ACTIVATE_BUTTON = 3'd2,
    REG_INIT_ON         = 3'd3,
    REG_HOLD_MODE       = 3'd4,
    REG_USE_BUTTON      = 3'd5,
    REG_USE_KEY         = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] retention;
    logic [15:0] ctrl_key;
    logic [15:0] activate_button;
    logic        init_on;
    logic        hold_mode;
    logic        use_button;
    logic        use_key;
    logic        start_wr;
    logic        start_val;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [15:0]        button_state;
    logic               move_absolute;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [15:0]        key_code;
    logic [1:0]         key_state;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        button_state_out;
    logic [15:0]        key_code_out;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               smoothing_on;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/mouse_motion_decay_smoother.sv
// Top level of the mouse motion decay smoother: ports, staging and result register.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  s_tuser = cmd, s_tdata = event fields
//   m_*      out        m_tvalid/m_tready  m_tuser = kind, m_tdata = result fields
//   APB      in/out     psel/penable       seven registers at byte address 4*i
//
// One item is taken every clock cycle unless a waiting result stalls the input register;
// each beat goes through the input register and then the result register.
// The feedback through the accumulators, the 40x16 decay multiply
// and the remainder add sets the clock period.
// Reset is synchronous and active high; it clears both accumulators, both
// remainders and the enable flag, and loads the register defaults.
// A full result register that is not taken stalls only items that give a result;
// items that give none keep flowing while a finished result waits.
`default_nettype none

module mouse_motion_decay_smoother (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input stream.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [15:0] button_state, [16] move_absolute, [32:17] delta_x, [48:33] delta_y,
  // [64:49] key_code, [66:65] key_state, [71:67] zero
  input  wire logic [mmds_pkg::IN_DATA_W-1:0]      s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]                          s_tuser,
  // Output stream.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [15:0] button_state_out, [31:16] key_code_out, [47:32] move_x,
  // [63:48] move_y, [64] smoothing_on, [71:65] zero
  output logic [mmds_pkg::OUT_DATA_W-1:0]          m_tdata,
  // [1:0] kind
  output logic [1:0]                               m_tuser,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mmds_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [mmds_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [mmds_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  mmds_pkg::cfg_t  cfg;
  mmds_pkg::item_t in_item;
  mmds_pkg::res_t  core_res;
  mmds_pkg::res_t  out_res;
  logic            in_valid;
  logic            out_valid;
  logic            has_result;
  logic            go;

  mmds_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The staged item moves on when it gives no result or the result register
  // is free or being emptied in this cycle.
  assign go       = in_valid && (!out_valid || m_tready || !has_result);
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd           <= mmds_pkg::cmd_e'(s_tuser);
      in_item.button_state  <= s_tdata[15:0];
      in_item.move_absolute <= s_tdata[16];
      in_item.delta_x       <= s_tdata[32:17];
      in_item.delta_y       <= s_tdata[48:33];
      in_item.key_code      <= s_tdata[64:49];
      in_item.key_state     <= s_tdata[66:65];
    end
  end

  mmds_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .go         (go),
    .item       (in_item),
    .has_result (has_result),
    .result     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && has_result) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {7'd0, out_res.smoothing_on, out_res.move_y, out_res.move_x,
                     out_res.key_code_out, out_res.button_state_out};

`ifndef SYNTH
  // A result produced by the core always shows up on the output next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (go && has_result) |=> m_tvalid)
    else $error("result from core did not reach the output register");

  // Generated motion only comes out while smoothing is on.
  a_motion_enabled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == mmds_pkg::KIND_MOTION)) |-> m_tdata[64])
    else $error("generated motion with smoothing off");
`endif

endmodule

`default_nettype wire

>>> rtl/mmds_cfg.sv
// Register file of the smoother behind an APB-style port.
`default_nettype none

module mmds_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mmds_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mmds_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [mmds_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output mmds_pkg::cfg_t                        cfg
);

  logic [15:0] retention;
  logic [15:0] ctrl_key;
  logic [15:0] activate_button;
  logic        init_on;
  logic        hold_mode;
  logic        use_button;
  logic        use_key;
  logic        wr;
  mmds_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = mmds_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      retention       <= 16'd61604;
      ctrl_key        <= '0;
      activate_button <= '0;
      init_on         <= 1'b0;
      hold_mode       <= 1'b0;
      use_button      <= 1'b0;
      use_key         <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        mmds_pkg::REG_RETENTION:       retention       <= pwdata[15:0];
        mmds_pkg::REG_CTRL_KEY:        ctrl_key        <= pwdata[15:0];
        mmds_pkg::REG_ACTIVATE_BUTTON: activate_button <= pwdata[15:0];
        mmds_pkg::REG_INIT_ON:         init_on         <= pwdata[0];
        mmds_pkg::REG_HOLD_MODE:       hold_mode       <= pwdata[0];
        mmds_pkg::REG_USE_BUTTON:      use_button      <= pwdata[0];
        mmds_pkg::REG_USE_KEY:         use_key         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mmds_pkg::REG_RETENTION:       prdata = {16'd0, retention};
      mmds_pkg::REG_CTRL_KEY:        prdata = {16'd0, ctrl_key};
      mmds_pkg::REG_ACTIVATE_BUTTON: prdata = {16'd0, activate_button};
      mmds_pkg::REG_INIT_ON:         prdata = {31'd0, init_on};
      mmds_pkg::REG_HOLD_MODE:       prdata = {31'd0, hold_mode};
      mmds_pkg::REG_USE_BUTTON:      prdata = {31'd0, use_button};
      mmds_pkg::REG_USE_KEY:         prdata = {31'd0, use_key};
      default:                       prdata = '0;
    endcase
  end

  // Writing the initial enable state also reloads the enable flag in the core.
  always_comb begin
    cfg.retention       = retention;
    cfg.ctrl_key        = ctrl_key;
    cfg.activate_button = activate_button;
    cfg.init_on         = init_on;
    cfg.hold_mode       = hold_mode;
    cfg.use_button      = use_button;
    cfg.use_key         = use_key;
    cfg.start_wr        = wr && (idx == mmds_pkg::REG_INIT_ON);
    cfg.start_val       = pwdata[0];
  end

endmodule

`default_nettype wire

>>> rtl/mmds_decay.sv
// One axis of a tick: decays the accumulator and splits off whole motion.
`default_nettype none

module mmds_decay (
  input  wire logic signed [mmds_pkg::ACC_W-1:0]  acc,
  input  wire logic signed [mmds_pkg::FRAC_W-1:0] frac,
  input  wire logic        [15:0]                 factor,
  output logic signed      [mmds_pkg::ACC_W-1:0]  kept,
  output logic signed      [mmds_pkg::FRAC_W-1:0] frac_next,
  output logic signed      [15:0]                 move
);

  localparam int AW      = mmds_pkg::ACC_W;
  localparam int FB      = mmds_pkg::FRAC_BITS;
  localparam int SUM_W   = AW + 2;
  localparam int WHOLE_W = SUM_W - FB;
  localparam logic [WHOLE_W-1:0] POS_LIMIT = WHOLE_W'(32767);
  localparam logic [WHOLE_W-1:0] NEG_LIMIT = WHOLE_W'(32768);

  logic                 acc_neg;
  logic [AW-1:0]        mag;
  logic [AW+15:0]       prod;
  logic [AW-1:0]        scaled;
  logic signed [SUM_W-1:0] sum;
  logic                 sum_neg;
  logic [SUM_W-1:0]     sum_mag;
  logic [WHOLE_W-1:0]   whole;
  logic [FB-1:0]        rest;

  // Scale the magnitude so that the product truncates toward zero.
  assign acc_neg = acc[AW-1];
  assign mag     = acc_neg ? AW'(-acc) : AW'(acc);
  assign prod    = (AW+16)'(mag) * (AW+16)'(factor);
  assign scaled  = prod[AW+15:16];
  assign kept    = acc_neg ? -$signed(scaled) : $signed(scaled);

  // Removed part plus the carried remainder.
  assign sum     = SUM_W'(acc) - SUM_W'(kept) + SUM_W'(frac);
  assign sum_neg = sum[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign whole   = sum_mag[SUM_W-1:FB];
  assign rest    = sum_mag[FB-1:0];

  assign frac_next = sum_neg ? -$signed({2'b00, rest}) : $signed({2'b00, rest});

  always_comb begin
    if (sum_neg) begin
      move = (whole > NEG_LIMIT) ? 16'sh8000 : -$signed(whole[15:0]);
    end else begin
      move = (whole > POS_LIMIT) ? 16'sh7fff : $signed(whole[15:0]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/mmds_core.sv
// Enable flag, accumulators and remainders, with the per-item update.
`default_nettype none

module mmds_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mmds_pkg::cfg_t  cfg,
  input  wire logic           go,
  input  wire mmds_pkg::item_t item,
  output logic                has_result,
  output mmds_pkg::res_t      result
);

  localparam int AW = mmds_pkg::ACC_W;
  localparam int FW = mmds_pkg::FRAC_W;
  localparam int FB = mmds_pkg::FRAC_BITS;

  logic signed [AW-1:0] acc_x, acc_y, acc_x_next, acc_y_next;
  logic signed [FW-1:0] frac_x, frac_y, frac_x_next, frac_y_next;
  logic                 enabled, enabled_next;

  logic signed [AW-1:0] kept_x, kept_y;
  logic signed [FW-1:0] dfrac_x, dfrac_y;
  logic signed [15:0]   dmove_x, dmove_y;
  logic [AW:0]          sum_x, sum_y;
  logic                 btn_on, btn_off, en_mouse, key_hit;

  function automatic logic [AW-1:0] sat_acc(input logic [AW:0] s);
    logic [AW-1:0] r;
    if (s[AW] != s[AW-1]) begin
      r = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      r = s[AW-1:0];
    end
    return r;
  endfunction

  mmds_decay u_decay_x (
    .acc       (acc_x),
    .frac      (frac_x),
    .factor    (cfg.retention),
    .kept      (kept_x),
    .frac_next (dfrac_x),
    .move      (dmove_x)
  );

  mmds_decay u_decay_y (
    .acc       (acc_y),
    .frac      (frac_y),
    .factor    (cfg.retention),
    .kept      (kept_y),
    .frac_next (dfrac_y),
    .move      (dmove_y)
  );

  assign btn_on   = cfg.use_button && (item.button_state == cfg.activate_button);
  assign btn_off  = cfg.use_button && !btn_on &&
                    ({1'b0, item.button_state} == {cfg.activate_button, 1'b0});
  assign en_mouse = btn_on ? 1'b1 : (btn_off ? 1'b0 : enabled);
  assign key_hit  = (item.key_code == cfg.ctrl_key);

  // Relative move scaled to Q24.FB, one guard bit for saturation.
  assign sum_x = {acc_x[AW-1], acc_x} +
                 {{(AW+1-16-FB){item.delta_x[15]}}, item.delta_x, {FB{1'b0}}};
  assign sum_y = {acc_y[AW-1], acc_y} +
                 {{(AW+1-16-FB){item.delta_y[15]}}, item.delta_y, {FB{1'b0}}};

  always_comb begin
    enabled_next = enabled;
    acc_x_next   = acc_x;
    acc_y_next   = acc_y;
    frac_x_next  = frac_x;
    frac_y_next  = frac_y;
    has_result   = 1'b0;
    result.kind             = mmds_pkg::KIND_MOUSE;
    result.button_state_out = '0;
    result.key_code_out     = '0;
    result.move_x           = '0;
    result.move_y           = '0;
    case (item.cmd)
      mmds_pkg::CMD_MOUSE: begin
        has_result              = 1'b1;
        enabled_next            = en_mouse;
        result.button_state_out = item.button_state;
        result.move_x           = item.delta_x;
        result.move_y           = item.delta_y;
        if (!en_mouse) begin
          acc_x_next = '0;
          acc_y_next = '0;
        end else if (!item.move_absolute) begin
          acc_x_next    = sat_acc(sum_x);
          acc_y_next    = sat_acc(sum_y);
          result.move_x = '0;
          result.move_y = '0;
        end
      end
      mmds_pkg::CMD_KEY: begin
        if (cfg.use_key) begin
          has_result          = 1'b1;
          result.kind         = mmds_pkg::KIND_KEY;
          result.key_code_out = item.key_code;
          if (key_hit) begin
            if (item.key_state == mmds_pkg::KEY_DOWN) begin
              if (cfg.hold_mode) begin
                enabled_next = !cfg.init_on;
              end
            end else if (item.key_state == mmds_pkg::KEY_UP) begin
              enabled_next = cfg.hold_mode ? cfg.init_on : !enabled;
            end
          end
          if (!enabled_next) begin
            acc_x_next = '0;
            acc_y_next = '0;
          end
        end
      end
      mmds_pkg::CMD_TICK: begin
        if (enabled && ((acc_x != '0) || (acc_y != '0))) begin
          has_result    = 1'b1;
          result.kind   = mmds_pkg::KIND_MOTION;
          result.move_x = dmove_x;
          result.move_y = dmove_y;
          acc_x_next    = kept_x;
          acc_y_next    = kept_y;
          frac_x_next   = dfrac_x;
          frac_y_next   = dfrac_y;
        end
      end
      default: ;
    endcase
    result.smoothing_on = enabled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      acc_x   <= '0;
      acc_y   <= '0;
      frac_x  <= '0;
      frac_y  <= '0;
    end else if (cfg.start_wr) begin
      enabled <= cfg.start_val;
      if (!cfg.start_val) begin
        acc_x <= '0;
        acc_y <= '0;
      end
    end else if (go) begin
      enabled <= enabled_next;
      acc_x   <= acc_x_next;
      acc_y   <= acc_y_next;
      frac_x  <= frac_x_next;
      frac_y  <= frac_y_next;
    end
  end

`ifndef SYNTH
  // The accumulators are empty whenever smoothing is off.
  a_off_clears: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> (acc_x == '0) && (acc_y == '0))
    else $error("accumulator holds motion while smoothing is off");

  // A tick only produces motion from a nonzero accumulator.
  a_tick_src: assert property (@(posedge clk) disable iff (rst)
    (go && has_result && (item.cmd == mmds_pkg::CMD_TICK)) |->
      enabled && ((acc_x != '0) || (acc_y != '0)))
    else $error("tick result without stored motion");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the mouse motion decay smoother.
`timescale 1ns / 1ps

module testbench;

  // Run limits. The watchdog limit is sized for the slowest correct run (every beat
  // behind the longest input gap and the longest output stall, plus the settling
  // pauses around register writes).
  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_LIMIT   = 10;

  // Fixed-point constants of the accumulators and remainders.
  localparam longint ONE_Q     = longint'(1) << mmds_pkg::FRAC_BITS;
  localparam longint FRAC_MASK = ONE_Q - 1;
  localparam longint ACC_HI    = (longint'(1) << (23 + mmds_pkg::FRAC_BITS)) - 1;
  localparam longint ACC_LO    = -ACC_HI - 1;

  localparam logic [15:0] DEFAULT_DECAY = 16'd61604;
  // Key state code with no name of its own; the block treats it like KEY_OTHER.
  localparam logic [1:0]  KEY_UNUSED    = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [mmds_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [1:0]                      s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [mmds_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0]                      m_tuser;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mmds_pkg::APB_ADDR_W-1:0] paddr;
  logic [mmds_pkg::APB_DATA_W-1:0] pwdata;
  logic [mmds_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  mouse_motion_decay_smoother dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 100 MHz clock, starting low so the first rising edge falls at 5 ns.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: register settings and smoothing state.
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_decay;
  logic [15:0] cfg_key;
  logic [15:0] cfg_button;
  logic        cfg_start_on;
  logic        cfg_hold;
  logic        cfg_use_button;
  logic        cfg_use_key;

  longint      acc_x;
  longint      acc_y;
  longint      rem_x;
  longint      rem_y;
  logic        smoothing;

  // Output beats that the block owes us, oldest first.
  mmds_pkg::res_t due_events[$];

  int             mismatch_count;
  int             cycle_count;
  bit             tx_idle_en;
  bit             rx_idle_en;
  int             rx_stall_left;
  mmds_pkg::res_t seen_event;
  mmds_pkg::res_t want_event;

  function automatic longint clamp_acc(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // The accumulators only hold motion while smoothing is on.
  function automatic void clear_when_off();
    if (!smoothing) begin
      acc_x = 0;
      acc_y = 0;
    end
  endfunction

  // One axis of a tick. The accumulator keeps decay/65536 of its magnitude (truncated),
  // the removed part joins the remainder, and the whole units of the remainder leave
  // as motion, truncated toward zero and clipped to 16 bits.
  task automatic decay_axis(inout longint acc, inout longint rem,
                            output logic signed [15:0] step);
    longint unsigned mag;
    longint unsigned kept_mag;
    longint unsigned sum_mag;
    longint          kept;
    longint          sum;
    longint          whole;
    longint          rest;
    mag      = (acc < 0) ? -acc : acc;
    kept_mag = (mag * {48'd0, cfg_decay}) >> 16;
    kept     = (acc < 0) ? -$signed(kept_mag) : $signed(kept_mag);
    sum      = rem + (acc - kept);
    sum_mag  = (sum < 0) ? -sum : sum;
    whole    = $signed(sum_mag >> mmds_pkg::FRAC_BITS);
    rest     = $signed(sum_mag & FRAC_MASK);
    acc      = kept;
    rem      = (sum < 0) ? -rest : rest;
    if (sum < 0) whole = -whole;
    if (whole > 32767) whole = 32767;
    if (whole < -32768) whole = -32768;
    step = whole[15:0];
  endtask

  // Applies one accepted input beat to the shadow state and queues the output beat
  // that it causes, if any.
  task automatic apply_event(input mmds_pkg::item_t it);
    mmds_pkg::res_t      r;
    bit                  emit;
    longint              dx;
    longint              dy;
    logic signed [15:0]  mx;
    logic signed [15:0]  my;
    r    = '0;
    emit = 1'b0;
    dx   = longint'(it.delta_x);
    dy   = longint'(it.delta_y);
    case (it.cmd)
      mmds_pkg::CMD_MOUSE: begin
        // The enable compare wins when the button code matches both values.
        if (cfg_use_button) begin
          if (it.button_state == cfg_button) smoothing = 1'b1;
          else if ({1'b0, it.button_state} == {cfg_button, 1'b0}) smoothing = 1'b0;
        end
        if (!it.move_absolute && smoothing) begin
          acc_x = clamp_acc(acc_x + dx * ONE_Q);
          acc_y = clamp_acc(acc_y + dy * ONE_Q);
          dx    = 0;
          dy    = 0;
        end
        clear_when_off();
        r.kind             = mmds_pkg::KIND_MOUSE;
        r.button_state_out = it.button_state;
        r.move_x           = dx[15:0];
        r.move_y           = dy[15:0];
        emit               = 1'b1;
      end
      mmds_pkg::CMD_KEY: begin
        if (cfg_use_key) begin
          if (it.key_code == cfg_key) begin
            if (it.key_state == mmds_pkg::KEY_DOWN) begin
              if (cfg_hold) smoothing = !cfg_start_on;
            end else if (it.key_state == mmds_pkg::KEY_UP) begin
              if (cfg_hold) smoothing = cfg_start_on;
              else smoothing = !smoothing;
            end
          end
          clear_when_off();
          r.kind         = mmds_pkg::KIND_KEY;
          r.key_code_out = it.key_code;
          emit           = 1'b1;
        end
      end
      mmds_pkg::CMD_TICK: begin
        if (smoothing && (acc_x != 0 || acc_y != 0)) begin
          decay_axis(acc_x, rem_x, mx);
          decay_axis(acc_y, rem_y, my);
          r.kind   = mmds_pkg::KIND_MOTION;
          r.move_x = mx;
          r.move_y = my;
          emit     = 1'b1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      r.smoothing_on = smoothing;
      due_events.push_back(r);
    end
  endtask

  task automatic apply_register(input mmds_pkg::reg_idx_e idx, input logic [31:0] value);
    case (idx)
      mmds_pkg::REG_RETENTION:       cfg_decay = value[15:0];
      mmds_pkg::REG_CTRL_KEY:        cfg_key = value[15:0];
      mmds_pkg::REG_ACTIVATE_BUTTON: cfg_button = value[15:0];
      mmds_pkg::REG_INIT_ON: begin
        // Writing the start state also loads the enable flag.
        cfg_start_on = value[0];
        smoothing    = value[0];
        clear_when_off();
      end
      mmds_pkg::REG_HOLD_MODE:       cfg_hold = value[0];
      mmds_pkg::REG_USE_BUTTON:      cfg_use_button = value[0];
      mmds_pkg::REG_USE_KEY:         cfg_use_key = value[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Bus drivers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------------

  // Register write: setup phase, then access phase until pready, then the bus goes idle.
  task automatic write_register(input mmds_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Sends one beat, optionally after a gap, and predicts it once accepted.
  // tvalid stays high afterwards so back-to-back beats have no bubble.
  task automatic send_item(input mmds_pkg::item_t it);
    int gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {5'd0, it.key_state, it.key_code, it.delta_y, it.delta_x,
                 it.move_absolute, it.button_state};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_event(it);
    @(negedge clk);
  endtask

  // Holds the sender until every owed beat has arrived, then lets the pipeline settle.
  // Beats that cause no output may still be in flight when the last output arrives.
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic mmds_pkg::item_t make_event(input mmds_pkg::cmd_e cmd,
                                                 input logic [15:0] bs,
                                                 input logic absolute,
                                                 input logic signed [15:0] dx,
                                                 input logic signed [15:0] dy,
                                                 input logic [15:0] kc,
                                                 input logic [1:0] ks);
    mmds_pkg::item_t it;
    it.cmd           = cmd;
    it.button_state  = bs;
    it.move_absolute = absolute;
    it.delta_x       = dx;
    it.delta_y       = dy;
    it.key_code      = kc;
    it.key_state     = ks;
    return it;
  endfunction

  function automatic logic signed [15:0] random_delta();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1:    return 16'(int'($urandom_range(0, 16)) - 8);
      2, 3:    return 16'(int'($urandom_range(0, 800)) - 400);
      4:       return r[0] ? 16'sh7FFF : 16'sh8000;
      default: return r[15:0];
    endcase
  endfunction

  // Random beat. Fields that the command does not use still carry random bits.
  function automatic mmds_pkg::item_t random_event();
    mmds_pkg::item_t it;
    logic [31:0]     r0;
    logic [31:0]     r1;
    int              pick;
    r0   = $urandom;
    r1   = $urandom;
    it   = make_event(mmds_pkg::CMD_TICK, r0[15:0], r0[16], r0[31:16], r1[15:0],
                      r1[31:16], 2'($urandom_range(0, 3)));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.cmd           = mmds_pkg::CMD_MOUSE;
      it.move_absolute = ($urandom_range(0, 9) == 0);
      it.delta_x       = random_delta();
      it.delta_y       = random_delta();
      case ($urandom_range(0, 4))
        0: it.button_state = cfg_button;
        1: it.button_state = {cfg_button[14:0], 1'b0};
        default: ;
      endcase
    end else if (pick < 80) begin
      it.cmd = mmds_pkg::CMD_TICK;
    end else if (pick < 95) begin
      it.cmd = mmds_pkg::CMD_KEY;
      if ($urandom_range(0, 1) == 0) it.key_code = cfg_key;
    end else begin
      it.cmd = mmds_pkg::CMD_NONE;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts on tready, and the checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_idle_en && rx_stall_left != 0) begin
      m_tready      <= 1'b0;
      rx_stall_left  = rx_stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      m_tready      <= 1'b0;
      rx_stall_left  = $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every accepted output beat is matched against the oldest owed beat.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_event.kind             = mmds_pkg::kind_e'(m_tuser);
      seen_event.button_state_out = m_tdata[15:0];
      seen_event.key_code_out     = m_tdata[31:16];
      seen_event.move_x           = m_tdata[47:32];
      seen_event.move_y           = m_tdata[63:48];
      seen_event.smoothing_on     = m_tdata[64];
      if (due_events.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected beat: kind=%0d bs=%h kc=%h mx=%0d my=%0d on=%0b",
                   seen_event.kind, seen_event.button_state_out,
                   seen_event.key_code_out, seen_event.move_x, seen_event.move_y,
                   seen_event.smoothing_on);
      end else begin
        want_event = due_events.pop_front();
        if (seen_event !== want_event) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch: expected kind=%0d bs=%h kc=%h mx=%0d my=%0d on=%0b, ",
                      "got kind=%0d bs=%h kc=%h mx=%0d my=%0d on=%0b"},
                     want_event.kind, want_event.button_state_out,
                     want_event.key_code_out, want_event.move_x, want_event.move_y,
                     want_event.smoothing_on, seen_event.kind,
                     seen_event.button_state_out, seen_event.key_code_out,
                     seen_event.move_x, seen_event.move_y, seen_event.smoothing_on);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset settings: buttons and keys have no say, smoothing is off, so moves pass
  // through untouched, keys vanish, ticks are silent and the unused command is dropped.
  task automatic test_reset_defaults();
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'hFFFF, 1'b0, 16'sh8000, 16'sh7FFF,
                         16'h0, mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_KEY, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_UP));
    send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_NONE, 16'hA5A5, 1'b1, 16'sh1234, 16'sh4321,
                         16'h5A5A, mmds_pkg::KEY_OTHER));
  endtask

  // Button codes: a zero code matches a zero enable code, twice the code disables,
  // and a doubled code that overflows 16 bits never matches.
  task automatic test_button_control();
    wait_for_idle();
    write_register(mmds_pkg::REG_ACTIVATE_BUTTON, 32'h0);
    write_register(mmds_pkg::REG_USE_BUTTON, 32'h1);
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h0, 1'b0, 16'sh7FFF, 16'sh8000, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
    // Absolute positions are never absorbed.
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h0, 1'b1, 16'sh0123, -16'sh0456, 16'h0,
                         mmds_pkg::KEY_DOWN));
    wait_for_idle();
    write_register(mmds_pkg::REG_ACTIVATE_BUTTON, 32'h4000);
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h8000, 1'b0, 16'sh0010, 16'sh0020, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
    wait_for_idle();
    write_register(mmds_pkg::REG_ACTIVATE_BUTTON, 32'h8001);
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h8001, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h0002, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
  endtask

  // With no retention the whole accumulator leaves on one tick and clips to 16 bits;
  // with full retention only a sliver leaves and lands in the remainder.
  task automatic test_motion_saturation();
    wait_for_idle();
    write_register(mmds_pkg::REG_RETENTION, 32'h0);
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h0, 1'b0, 16'sh7FFF, 16'sh8000, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h0, 1'b0, 16'sh7FFF, 16'sh8000, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
    wait_for_idle();
    write_register(mmds_pkg::REG_RETENTION, 32'hFFFF);
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h0, 1'b0, 16'sh0001, -16'sh0001, 16'h0,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
  endtask

  // Key control in toggle mode and then in hold mode, plus the unnamed key state
  // and a key code that does not match.
  task automatic test_key_modes();
    wait_for_idle();
    write_register(mmds_pkg::REG_USE_KEY, 32'h1);
    write_register(mmds_pkg::REG_CTRL_KEY, 32'hFFFF);
    write_register(mmds_pkg::REG_HOLD_MODE, 32'h0);
    send_item(make_event(mmds_pkg::CMD_KEY, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'hFFFF,
                         mmds_pkg::KEY_UP));
    send_item(make_event(mmds_pkg::CMD_KEY, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'hFFFF,
                         KEY_UNUSED));
    send_item(make_event(mmds_pkg::CMD_KEY, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'hFFFF,
                         mmds_pkg::KEY_DOWN));
    wait_for_idle();
    write_register(mmds_pkg::REG_HOLD_MODE, 32'h1);
    write_register(mmds_pkg::REG_INIT_ON, 32'h0);
    send_item(make_event(mmds_pkg::CMD_KEY, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'hFFFF,
                         mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_MOUSE, 16'h1234, 1'b0, 16'sh0064, -16'sh0064,
                         16'h0, mmds_pkg::KEY_DOWN));
    send_item(make_event(mmds_pkg::CMD_KEY, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'hFFFF,
                         mmds_pkg::KEY_UP));
    send_item(make_event(mmds_pkg::CMD_KEY, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0000,
                         mmds_pkg::KEY_UP));
    send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                         mmds_pkg::KEY_DOWN));
  endtask

  // Drives both accumulators into their limits with a long run of extreme moves,
  // then drops retention to zero so a saturated accumulator leaves in one tick.
  task automatic test_accumulator_limits();
    int i;
    wait_for_idle();
    write_register(mmds_pkg::REG_RETENTION, 32'hFFFF);
    write_register(mmds_pkg::REG_USE_BUTTON, 32'h0);
    write_register(mmds_pkg::REG_INIT_ON, 32'h1);
    for (i = 0; i < 320; i++) begin
      if (i % 16 == 15)
        send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                             mmds_pkg::KEY_DOWN));
      else
        send_item(make_event(mmds_pkg::CMD_MOUSE, 16'($urandom), 1'b0, 16'sh7FFF,
                             16'sh8000, 16'h0, mmds_pkg::KEY_DOWN));
    end
    wait_for_idle();
    write_register(mmds_pkg::REG_RETENTION, 32'h0);
    for (i = 0; i < 3; i++)
      send_item(make_event(mmds_pkg::CMD_TICK, 16'h0, 1'b0, 16'sh0, 16'sh0, 16'h0,
                           mmds_pkg::KEY_DOWN));
  endtask

  // Picks and writes a full register set; extremes come up often.
  task automatic program_random_settings();
    logic [31:0] r;
    logic [15:0] decay;
    logic [15:0] button;
    r = $urandom;
    case ($urandom_range(0, 4))
      0:       decay = 16'h0000;
      1:       decay = 16'hFFFF;
      2:       decay = DEFAULT_DECAY;
      3:       decay = 16'h8000;
      default: decay = r[15:0];
    endcase
    case ($urandom_range(0, 3))
      0:       button = 16'h0000;
      1:       button = 16'hFFFF;
      2:       button = 16'h8000;
      default: button = r[31:16];
    endcase
    write_register(mmds_pkg::REG_RETENTION, {16'd0, decay});
    write_register(mmds_pkg::REG_CTRL_KEY, {16'd0, 16'($urandom)});
    write_register(mmds_pkg::REG_ACTIVATE_BUTTON, {16'd0, button});
    write_register(mmds_pkg::REG_HOLD_MODE, {31'd0, 1'($urandom)});
    write_register(mmds_pkg::REG_USE_BUTTON, {31'd0, 1'($urandom)});
    write_register(mmds_pkg::REG_USE_KEY, {31'd0, 1'($urandom)});
    // Smoothing mostly starts on so that moves reach the accumulators.
    write_register(mmds_pkg::REG_INIT_ON, {31'd0, 1'($urandom_range(0, 3) != 0)});
  endtask

  // Random traffic in phases, each with its own settings and idling mix.
  // The last phase runs with no idling on either side.
  task automatic test_random_traffic(input int target);
    localparam int PHASES = 10;
    int              phase;
    int              done;
    bit              last;
    mmds_pkg::item_t it;
    for (phase = 0; phase < PHASES; phase++) begin
      last = (phase == PHASES - 1);
      wait_for_idle();
      tx_idle_en = !last && ($urandom_range(0, 3) != 0);
      rx_idle_en = !last && ($urandom_range(0, 3) != 0);
      program_random_settings();
      done = 0;
      while (done < target / PHASES) begin
        it = random_event();
        if (it.cmd != mmds_pkg::CMD_NONE && !(it.cmd == mmds_pkg::CMD_KEY && !cfg_use_key))
          done++;
        send_item(it);
        // Now and then the sender holds until the block has drained.
        if ($urandom_range(0, 299) == 0) wait_for_idle();
      end
    end
  endtask

  task automatic finish_run();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_events.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: known inputs from time zero, then reset, then the tests.
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    rx_stall_left  = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    cfg_decay      = DEFAULT_DECAY;
    cfg_key        = '0;
    cfg_button     = '0;
    cfg_start_on   = 1'b0;
    cfg_hold       = 1'b0;
    cfg_use_button = 1'b0;
    cfg_use_key    = 1'b0;
    acc_x          = 0;
    acc_y          = 0;
    rem_x          = 0;
    rem_y          = 0;
    smoothing      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_button_control();
    test_motion_saturation();
    test_key_modes();
    test_accumulator_limits();
    test_random_traffic(1000);
    finish_run();
  end

endmodule

>>> mouse_motion_decay_smoother.f
rtl/mmds_pkg.sv
rtl/mmds_cfg.sv
rtl/mmds_decay.sv
rtl/mmds_core.sv
rtl/mouse_motion_decay_smoother.sv
sim/testbench.sv
